>>> src/bitmap_page_allocator_assert.svh
// ----------------------------------------------------------------------------
// bitmap_page_allocator_assert.svh
// assertion macros used by the allocator sequencer (bpa_ctrl)
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BPA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap page allocator assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap page allocator assertion failed");

`endif

>>> src/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// types, codes and helpers shared by the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int ADDR_W      = 24;
    localparam int COUNT_W     = 13;
    localparam int TOTAL_W     = 13;
    localparam int WORD_BITS   = 64;
    localparam int WORD_SHIFT  = 6;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_PAGES_RESET = 13'd4096;

    // register index, taken from paddr bit 2
    localparam logic REG_TOTAL_PAGES = 1'b0;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_FREE    = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;
    localparam logic [1:0] FUNC_RESERVE = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [ADDR_W-1:0]  address;
        logic [COUNT_W-1:0] page_count;
    } bpa_req_t;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] page_address;
    } bpa_resp_t;

    // controller to datapath
    typedef struct packed {
        logic clear;      // write one all-ones word of the power-up fill
        logic load;       // capture a new item
        logic prime;      // issue the first word read
        logic scan;       // process the word on the read port
        logic fin_empty;  // finish an item that touches no word
    } bpa_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic empty;
        logic scan_last;
    } bpa_sts_t;

    // index of the lowest set bit, six halving steps
    function automatic logic [WORD_SHIFT-1:0] lowest_one(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0]  x;
        logic [WORD_SHIFT-1:0] idx;
        x   = v;
        idx = '0;
        for (int k = WORD_SHIFT - 1; k >= 0; k--)
        begin
            if ((x & ((64'd1 << (1 << k)) - 64'd1)) == 64'd0)
            begin
                idx[k] = 1'b1;
                x      = x >> (1 << k);
            end
        end
        return idx;
    endfunction

endpackage

>>> src/bpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/bpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ctrl
// sequencer: power-up fill, item setup, word scan and result beat
// ----------------------------------------------------------------------------
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  bpa_sts_t sts,
    output bpa_ctl_t ctl,
    output logic     busy,
    output logic     done
);

`include "bitmap_page_allocator_assert.svh"

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, done_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_INIT:
            begin
                ctl.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (sts.empty)
                begin
                    ctl.fin_empty = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    ctl.prime  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctl.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
            done_reg  <= (state_next == ST_DONE);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    `BPA_ASSERT_NEXT(a_done_single, done_reg, !done_reg)
    `BPA_ASSERT_NEXT(a_accept_busy, start && !busy_reg, busy_reg && !done_reg)
    `BPA_ASSERT_SAME(a_done_while_busy, done_reg, busy_reg && state_reg == ST_DONE)

endmodule

>>> src/bpa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_datapath
// bitmap ram, page range bounds, word mask, first-free search, result
// ----------------------------------------------------------------------------
module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_SHIFT = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bpa_ctl_t           ctl,
    input  bpa_req_t           req,
    input  logic [TOTAL_W-1:0] total_pages,
    output bpa_sts_t           sts,
    output bpa_resp_t          resp
);

    localparam int WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PGW   = ADDR_W - PAGE_SHIFT;
    // page numbers, range ends and the limit all fit with one spare bit
    localparam int IW    = ((PGW > TOTAL_W) ? PGW : TOTAL_W) + 1;
    localparam int CAP   = (MAX_PAGES < 8192) ? MAX_PAGES : 8192;
    localparam int SHW   = IW + PAGE_SHIFT;

    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
    localparam logic [IW-1:0]  CAP_IW    = IW'(CAP);

    // item context
    logic [IW-1:0]  lo_reg, hi_reg;
    logic [WAW-1:0] end_word_reg, start_word_reg;
    logic           alloc_reg, mark_reg, empty_reg;
    logic [WAW-1:0] w_cur_reg;

    logic           status_reg;
    logic [ADDR_W-1:0] page_addr_reg;

    // load-time bounds
    logic [IW-1:0] pg, cnt, lim, lo_n, hi_n, hi_c, hi_m1;
    logic          alloc_n;

    // scan
    logic [WORD_BITS-1:0]  rdata, mask, cand, new_word, wdata;
    logic [WORD_SHIFT-1:0] hit_idx;
    logic                  hit;
    logic [IW-WORD_SHIFT-1:0] base_word;
    logic [IW-1:0]         hit_page;
    logic [SHW-1:0]        hit_shift;
    logic [WAW-1:0]        raddr, waddr;
    logic                  we;

    always_comb
    begin
        pg      = IW'(req.address[ADDR_W-1:PAGE_SHIFT]);
        cnt     = IW'(req.page_count);
        lim     = (IW'(total_pages) > CAP_IW) ? CAP_IW : IW'(total_pages);
        alloc_n = (req.func == FUNC_ALLOC);
        case (req.func)
            FUNC_ALLOC:
            begin
                lo_n = '0;
                hi_n = lim;
            end
            FUNC_FREE:
            begin
                lo_n = pg;
                hi_n = pg + IW'(1);
            end
            default:
            begin
                lo_n = pg;
                hi_n = pg + cnt;
            end
        endcase
        hi_c  = (hi_n > lim) ? lim : hi_n;
        hi_m1 = hi_c - IW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            lo_reg         <= lo_n;
            hi_reg         <= hi_c;
            empty_reg      <= (lo_n >= hi_c);
            start_word_reg <= WAW'(lo_n >> WORD_SHIFT);
            end_word_reg   <= WAW'(hi_m1 >> WORD_SHIFT);
            alloc_reg      <= alloc_n;
            mark_reg       <= (req.func == FUNC_RESERVE);
        end
    end

    // word counter runs the power-up fill and the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_cur_reg <= '0;
        end
        else if (ctl.prime)
        begin
            w_cur_reg <= start_word_reg;
        end
        else if (ctl.clear || ctl.scan)
        begin
            w_cur_reg <= w_cur_reg + WAW'(1);
        end
    end

    // bits of the current word that fall inside [lo, hi)
    always_comb
    begin
        base_word = (IW-WORD_SHIFT)'(w_cur_reg);
        for (int i = 0; i < WORD_BITS; i++)
        begin
            mask[i] = ({base_word, WORD_SHIFT'(i)} >= lo_reg) &&
                      ({base_word, WORD_SHIFT'(i)} <  hi_reg);
        end
        cand      = ~rdata & mask;
        hit       = alloc_reg && (cand != '0);
        hit_idx   = lowest_one(cand);
        hit_page  = {base_word, hit_idx};
        hit_shift = {hit_page, {PAGE_SHIFT{1'b0}}};
        if (alloc_reg)
        begin
            new_word = hit ? (rdata | (64'd1 << hit_idx)) : rdata;
        end
        else
        begin
            new_word = mark_reg ? (rdata | mask) : (rdata & ~mask);
        end
    end

    // one word read per cycle, the next word is fetched while this one is written
    assign raddr = ctl.prime ? start_word_reg : (w_cur_reg + WAW'(1));
    assign waddr = w_cur_reg;
    assign we    = ctl.clear || ctl.scan;
    assign wdata = ctl.clear ? '1 : new_word;

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS),
        .AW    (WAW)
    ) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.fin_empty)
        begin
            status_reg    <= alloc_reg;
            page_addr_reg <= '0;
        end
        else if (ctl.scan)
        begin
            status_reg    <= alloc_reg && !hit;
            page_addr_reg <= hit ? hit_shift[ADDR_W-1:0] : '0;
        end
    end

    assign sts.clear_last   = (w_cur_reg == LAST_WORD);
    assign sts.empty        = empty_reg;
    assign sts.scan_last    = hit || (w_cur_reg == end_word_reg);
    assign resp.status       = status_reg;
    assign resp.page_address = page_addr_reg;

endmodule

>>> src/bitmap_page_allocator.sv
// an accepted item runs a setup step, a scan over the bitmap words it visits and a result beat
// (allocate stops at the first word with a free page, a range walks its words)
// the scan takes one bitmap word per cycle on the ram; a new item is taken only after the result beat
// an item that touches no page skips the scan and goes from setup to its result beat
// after reset, busy stays high while the bitmap fills to used
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// first-fit page frame allocator over a used/free bitmap held in ram
// ----------------------------------------------------------------------------
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // command side: beat taken when start is high and busy is low
    input  logic                  start,
    input  bpa_req_t              req,
    output logic                  busy,

    // result side: one beat per item, valid for the single cycle done is high
    output logic                  done,
    output bpa_resp_t             resp,

    // apb register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // total_pages register, word index in paddr bit 2
    logic [TOTAL_W-1:0] total_pages_reg;
    logic               reg_wr;

    bpa_ctl_t ctl;
    bpa_sts_t sts;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_pages_reg <= TOTAL_PAGES_RESET;
        end
        else if (reg_wr && (paddr[2] == REG_TOTAL_PAGES))
        begin
            total_pages_reg <= pwdata[TOTAL_W-1:0];
        end
    end

    // unknown register slots read as zero
    assign prdata = (paddr[2] == REG_TOTAL_PAGES) ? APB_DATA_W'(total_pages_reg) : '0;

    // sequencer: fill, setup, scan, result beat
    bpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // bitmap ram, range bounds and first-free search
    bpa_datapath #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .req         (req),
        .total_pages (total_pages_reg),
        .sts         (sts),
        .resp        (resp)
    );

endmodule
